[rtl/core/hbc_pkg.sv]
// Shared types and constants of the hue brightness correction table.
`default_nettype none
package hbc_pkg;

	typedef enum logic [2:0] {
		CMD_QUERY    = 3'd0,
		CMD_NEXT     = 3'd1,
		CMD_PREV     = 3'd2,
		CMD_BRIGHTEN = 3'd3,
		CMD_DARKEN   = 3'd4,
		CMD_RESET    = 3'd5
	} cmd_t;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_STEP = 1'b1;

	localparam logic [7:0] NEUTRAL    = 8'd128;
	localparam logic [7:0] BASE_RESET = 8'd180;
	localparam logic [7:0] STEP_RESET = 8'd5;

	// one beat handed from the table stage to the interpolation stage
	typedef struct packed {
		logic       valid;
		logic       query;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] f;
		logic [7:0] entry;
		logic [3:0] anchor;
	} lerp_req_t;

endpackage
`default_nettype wire

[rtl/core/hbc_ram.sv]
// Generic single write, single registered read RAM.
`default_nettype none
module hbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/hbc_hue_split.sv]
// Splits a hue into segment anchors and in-segment offset.
`default_nettype none
module hbc_hue_split #(
	parameter int ANCHOR_COUNT = 16
) (
	input  wire logic [7:0]                        hue,
	output logic      [$clog2(ANCHOR_COUNT)-1:0]   idx_lo,
	output logic      [$clog2(ANCHOR_COUNT)-1:0]   idx_hi,
	output logic      [$clog2(256/ANCHOR_COUNT)-1:0] offset
);

	localparam int AW   = $clog2(ANCHOR_COUNT);
	localparam int STEP = 256 / ANCHOR_COUNT;
	localparam int OW   = $clog2(STEP);
	localparam int R1   = ((1 << 24) + STEP - 1) / STEP;

	localparam logic [7:0]    LAST  = 8'(ANCHOR_COUNT - 1);
	localparam logic [AW-1:0] LASTA = AW'(ANCHOR_COUNT - 1);
	localparam logic [7:0]    OMAX  = 8'(STEP - 1);

	logic [31:0] prod;
	logic [7:0]  quot;
	logic [7:0]  idx_w;
	logic [7:0]  seg_base;
	logic [7:0]  off_full;

	always_comb begin
		prod  = 32'(hue) * 32'(R1);
		quot  = prod[31:24];
		if (quot > LAST) begin
			idx_lo = LASTA;
		end else begin
			idx_lo = quot[AW-1:0];
		end
		if (idx_lo == LASTA) begin
			idx_hi = '0;
		end else begin
			idx_hi = idx_lo + AW'(1);
		end
		idx_w    = 8'(idx_lo);
		seg_base = idx_w * 8'(STEP);
		off_full = hue - seg_base;
		if (off_full > OMAX) begin
			offset = OMAX[OW-1:0];
		end else begin
			offset = off_full[OW-1:0];
		end
	end

endmodule
`default_nettype wire

[rtl/core/hbc_lerp.sv]
// Interpolation, brightness clamp and result register.
`default_nettype none
module hbc_lerp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire hbc_pkg::lerp_req_t req,
	input  wire logic [7:0]       base_brightness,
	output logic                  done,
	output logic      [7:0]       final_value,
	output logic      [7:0]       raw_correction,
	output logic      [3:0]       anchor_index,
	output logic      [7:0]       anchor_correction
);

	import hbc_pkg::*;

	lerp_req_t   req_s2;
	logic        up;
	logic [7:0]  diff;
	logic [16:0] prod;
	logic [7:0]  scaled;
	logic [7:0]  raw;
	logic [9:0]  v;
	logic [7:0]  fin;
	logic        done_q;
	logic [7:0]  final_q;
	logic [7:0]  raw_q;
	logic [3:0]  anchor_q;
	logic [7:0]  entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s2 <= '0;
		end else begin
			req_s2 <= req;
		end
	end

	always_comb begin
		up     = req_s2.b > req_s2.a;
		diff   = up ? (req_s2.b - req_s2.a) : (req_s2.a - req_s2.b);
		prod   = 17'(diff) * (17'(req_s2.f) + 17'd1);
		scaled = prod[15:8];
		if (req_s2.query) begin
			raw = up ? (req_s2.a + scaled) : (req_s2.a - scaled);
		end else begin
			raw = req_s2.entry;
		end
		v = 10'(base_brightness) + 10'(raw) - 10'(NEUTRAL);
		if (v[9]) begin
			fin = 8'd0;
		end else if (v[8]) begin
			fin = 8'hFF;
		end else begin
			fin = v[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= req_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		final_q  <= fin;
		raw_q    <= raw;
		anchor_q <= req_s2.anchor;
		entry_q  <= req_s2.entry;
	end

	assign done              = done_q;
	assign final_value       = final_q;
	assign raw_correction    = raw_q;
	assign anchor_index      = anchor_q;
	assign anchor_correction = entry_q;

endmodule
`default_nettype wire

[rtl/core/hue_brightness_correction_table.sv]
// Top level: hue brightness correction table with linear interpolation.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+---------------------------
//  command  | cmd, hue                                | start high, busy low
//  result   | final_value, raw_correction,            | done strobe, one cycle
//           | anchor_index, anchor_correction         |
//  config   | wr_index, wr_data                       | wr_en high
//
//  One command beat per cycle; the result strobe is registered through valid_s1, req_s2 and done_q.
//  The pace is set by the one-deep write forwarding around the table RAM read port.
//  After reset every entry reads neutral through per-entry valid bits; no clearing pass.
//  busy never rises; the receiver cannot stall, so no result is ever held.
`default_nettype none
module hue_brightness_correction_table #(
	parameter int ANCHOR_COUNT = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [2:0] cmd,
	input  wire logic [7:0] hue,
	output logic            done,
	output logic      [7:0] final_value,
	output logic      [7:0] raw_correction,
	output logic      [3:0] anchor_index,
	output logic      [7:0] anchor_correction,
	input  wire logic       wr_en,
	input  wire logic       wr_index,
	input  wire logic [7:0] wr_data
);

	import hbc_pkg::*;

	localparam int AW   = $clog2(ANCHOR_COUNT);
	localparam int STEP = 256 / ANCHOR_COUNT;
	localparam int OW   = $clog2(STEP);
	localparam int R2   = ((1 << 30) + STEP - 2) / (STEP - 1);

	localparam logic [AW-1:0] LASTA = AW'(ANCHOR_COUNT - 1);

	logic                    acc;
	cmd_t                    cmd_in;
	logic [7:0]              base_q;
	logic [7:0]              step_q;
	logic [AW-1:0]           sel_q;
	logic [AW-1:0]           sel_next;
	logic [AW-1:0]           idx_lo;
	logic [AW-1:0]           idx_hi;
	logic [OW-1:0]           offset;
	logic [ANCHOR_COUNT-1:0] vld_q;

	logic                    valid_s1;
	cmd_t                    cmd_s1;
	logic [AW-1:0]           lo_s1;
	logic [AW-1:0]           hi_s1;
	logic [AW-1:0]           sel_s1;
	logic [OW-1:0]           off_s1;
	logic                    vlo_s1;
	logic                    vhi_s1;
	logic                    vsel_s1;
	logic [7:0]              rd_lo;
	logic [7:0]              rd_hi;
	logic [7:0]              rd_sel;

	logic                    wr_q;
	logic                    clr_q;
	logic [AW-1:0]           wr_addr_q;
	logic [7:0]              wr_data_q;

	logic [7:0]              ent_a;
	logic [7:0]              ent_b;
	logic [7:0]              ent_sel;
	logic [8:0]              sum9;
	logic [7:0]              new_e;
	logic                    tbl_we;
	logic                    tbl_clr;
	logic [15:0]             off255;
	logic [46:0]             fprod;
	logic [AW+3:0]           sel_ext;
	lerp_req_t               req;

	function automatic logic [7:0] pick(
		input logic [7:0]    rd,
		input logic          vb,
		input logic [AW-1:0] addr,
		input logic          clr,
		input logic          wr,
		input logic [AW-1:0] waddr,
		input logic [7:0]    wdata
	);
		logic [7:0] r;
		if (clr) begin
			r = NEUTRAL;
		end else if (wr && (waddr == addr)) begin
			r = wdata;
		end else if (vb) begin
			r = rd;
		end else begin
			r = NEUTRAL;
		end
		return r;
	endfunction

	assign busy   = 1'b0;
	assign acc    = start && !busy;
	assign cmd_in = cmd_t'(cmd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
			step_q <= STEP_RESET;
		end else if (wr_en) begin
			if (wr_index == REG_BASE) begin
				base_q <= wr_data;
			end else if (wr_index == REG_STEP) begin
				step_q <= wr_data;
			end
		end
	end

	always_comb begin
		unique case (cmd_in)
			CMD_NEXT: begin
				sel_next = (sel_q == LASTA) ? '0 : sel_q + AW'(1);
			end
			CMD_PREV: begin
				sel_next = (sel_q == '0) ? LASTA : sel_q - AW'(1);
			end
			default: begin
				sel_next = sel_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= '0;
		end else if (acc) begin
			sel_q <= sel_next;
		end
	end

	hbc_hue_split #(.ANCHOR_COUNT(ANCHOR_COUNT)) u_split (
		.hue    (hue),
		.idx_lo (idx_lo),
		.idx_hi (idx_hi),
		.offset (offset)
	);

	hbc_ram #(.WIDTH(8), .DEPTH(ANCHOR_COUNT)) u_ram_lo (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (sel_s1),
		.wdata (new_e),
		.raddr (idx_lo),
		.rdata (rd_lo)
	);

	hbc_ram #(.WIDTH(8), .DEPTH(ANCHOR_COUNT)) u_ram_hi (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (sel_s1),
		.wdata (new_e),
		.raddr (idx_hi),
		.rdata (rd_hi)
	);

	hbc_ram #(.WIDTH(8), .DEPTH(ANCHOR_COUNT)) u_ram_sel (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (sel_s1),
		.wdata (new_e),
		.raddr (sel_next),
		.rdata (rd_sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1  <= cmd_in;
		lo_s1   <= idx_lo;
		hi_s1   <= idx_hi;
		sel_s1  <= sel_next;
		off_s1  <= offset;
		vlo_s1  <= vld_q[idx_lo];
		vhi_s1  <= vld_q[idx_hi];
		vsel_s1 <= vld_q[sel_next];
	end

	// entries as of the previous beat's write or clear
	always_comb begin
		ent_a   = pick(rd_lo, vlo_s1, lo_s1, clr_q, wr_q, wr_addr_q, wr_data_q);
		ent_b   = pick(rd_hi, vhi_s1, hi_s1, clr_q, wr_q, wr_addr_q, wr_data_q);
		ent_sel = pick(rd_sel, vsel_s1, sel_s1, clr_q, wr_q, wr_addr_q, wr_data_q);
		sum9    = 9'(ent_sel) + 9'(step_q);
		unique case (cmd_s1)
			CMD_BRIGHTEN: begin
				new_e = sum9[8] ? 8'hFF : sum9[7:0];
			end
			CMD_DARKEN: begin
				new_e = (ent_sel > step_q) ? (ent_sel - step_q) : 8'd0;
			end
			CMD_RESET: begin
				new_e = NEUTRAL;
			end
			default: begin
				new_e = ent_sel;
			end
		endcase
		tbl_we  = valid_s1 && ((cmd_s1 == CMD_BRIGHTEN) || (cmd_s1 == CMD_DARKEN));
		tbl_clr = valid_s1 && (cmd_s1 == CMD_RESET);
		off255  = (16'(off_s1) << 8) - 16'(off_s1);
		fprod   = 47'(off255) * 47'(R2);
		sel_ext = {4'b0, sel_s1};

		req.valid  = valid_s1;
		req.query  = (cmd_s1 == CMD_QUERY);
		req.a      = ent_a;
		req.b      = ent_b;
		req.f      = fprod[37:30];
		req.entry  = new_e;
		req.anchor = sel_ext[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			wr_q  <= 1'b0;
			clr_q <= 1'b0;
		end else begin
			wr_q  <= tbl_we;
			clr_q <= tbl_clr;
			if (tbl_clr) begin
				vld_q <= '0;
			end else if (tbl_we) begin
				vld_q[sel_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= sel_s1;
		wr_data_q <= new_e;
	end

	hbc_lerp u_lerp (
		.clk               (clk),
		.arst_n            (arst_n),
		.req               (req),
		.base_brightness   (base_q),
		.done              (done),
		.final_value       (final_value),
		.raw_correction    (raw_correction),
		.anchor_index      (anchor_index),
		.anchor_correction (anchor_correction)
	);

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##3 done)
		else $error("result beat missing three cycles after accept");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(acc, 3))
		else $error("result beat without matching command beat");

	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(sel_q))
		else $error("anchor pointer moved without a command beat");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_clr |=> (clr_q && (vld_q == '0)))
		else $error("table reset did not clear the valid bits");
`endif

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// Testbench for hue_brightness_correction_table: directed and random commands, scoreboard.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hbc_pkg::*;

	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;
	localparam int QUIET_LIMIT = 1000;

	typedef struct packed {
		logic [7:0] final_value;
		logic [7:0] raw_correction;
		logic [3:0] anchor_index;
		logic [7:0] anchor_correction;
	} correction_result_t;

	class correction_scoreboard;
		logic [7:0] entries [16];
		logic [3:0] pointer;
		logic [7:0] base;
		logic [7:0] step;
		correction_result_t pending_corrections [$];
		int errors;

		function new();
			foreach (entries[k]) entries[k] = NEUTRAL;
			pointer = '0;
			base = BASE_RESET;
			step = STEP_RESET;
			errors = 0;
		endfunction

		function void write_reg(logic idx, logic [7:0] data);
			if (idx == REG_BASE) begin
				base = data;
			end else begin
				step = data;
			end
		endfunction

		function logic [7:0] interpolate_hue(logic [7:0] h);
			int a, b, f, d;
			a = entries[h[7:4]];
			b = entries[h[7:4] + 4'd1];
			f = h[3:0] * 17;
			d = (b > a) ? b - a : a - b;
			d = (d * (f + 1)) >> 8;
			return (b > a) ? 8'(a + d) : 8'(a - d);
		endfunction

		function void note_command(logic [2:0] c, logic [7:0] h);
			correction_result_t r;
			int e;
			int v;
			case (c)
				CMD_NEXT: pointer = pointer + 4'd1;
				CMD_PREV: pointer = pointer - 4'd1;
				CMD_BRIGHTEN: begin
					e = int'(entries[pointer]) + int'(step);
					entries[pointer] = (e > 255) ? 8'd255 : 8'(e);
				end
				CMD_DARKEN: begin
					e = int'(entries[pointer]) - int'(step);
					entries[pointer] = (e < 0) ? 8'd0 : 8'(e);
				end
				CMD_RESET: foreach (entries[k]) entries[k] = NEUTRAL;
				default: ;
			endcase
			r.raw_correction = (c == CMD_QUERY) ? interpolate_hue(h) : entries[pointer];
			v = int'(base) + int'(r.raw_correction) - int'(NEUTRAL);
			if (v < 0) v = 0;
			if (v > 255) v = 255;
			r.final_value = 8'(v);
			r.anchor_index = pointer;
			r.anchor_correction = entries[pointer];
			pending_corrections.push_back(r);
		endfunction

		function void check_result(logic [7:0] fv, logic [7:0] raw, logic [3:0] idx,
				logic [7:0] entry);
			correction_result_t exp;
			if (pending_corrections.size() == 0) begin
				$error("result beat with no command outstanding");
				errors++;
				return;
			end
			exp = pending_corrections.pop_front();
			if (fv !== exp.final_value) begin
				$error("final_value: expected %0d, got %0d", exp.final_value, fv);
				errors++;
			end
			if (raw !== exp.raw_correction) begin
				$error("raw_correction: expected %0d, got %0d", exp.raw_correction, raw);
				errors++;
			end
			if (idx !== exp.anchor_index) begin
				$error("anchor_index: expected %0d, got %0d", exp.anchor_index, idx);
				errors++;
			end
			if (entry !== exp.anchor_correction) begin
				$error("anchor_correction: expected %0d, got %0d", exp.anchor_correction, entry);
				errors++;
			end
		endfunction

		function int pending_count();
			return pending_corrections.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [2:0] cmd;
	logic [7:0] hue;
	logic done;
	logic [7:0] final_value;
	logic [7:0] raw_correction;
	logic [3:0] anchor_index;
	logic [7:0] anchor_correction;
	logic wr_en;
	logic wr_index;
	logic [7:0] wr_data;

	correction_scoreboard sb = new();
	int idle_pct;
	int quiet_cycles;

	hue_brightness_correction_table dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.hue(hue),
		.done(done),
		.final_value(final_value),
		.raw_correction(raw_correction),
		.anchor_index(anchor_index),
		.anchor_correction(anchor_correction),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// monitor and watchdog
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note_command(cmd, hue);
			if (wr_en) sb.write_reg(wr_index, wr_data);
			if (done) sb.check_result(final_value, raw_correction, anchor_index,
				anchor_correction);
			if ((start && !busy) || done) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// leaves start high on return unless it inserts an idle beat; wait_for_results lowers it
	task automatic send_command(input logic [2:0] c, input logic [7:0] h);
		start <= 1'b1;
		cmd <= c;
		hue <= h;
		do @(posedge clk); while (busy);
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			cmd <= 3'($urandom);
			hue <= 8'($urandom);
			@(posedge clk);
		end
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		do @(negedge clk); while (sb.pending_count() != 0);
		@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] base, input logic [7:0] step);
		wr_en <= 1'b1;
		wr_index <= REG_BASE;
		wr_data <= base;
		@(posedge clk);
		wr_index <= REG_STEP;
		wr_data <= step;
		@(posedge clk);
		wr_en <= 1'b0;
		wr_data <= 8'($urandom);
	endtask

	task automatic run_random(input int count);
		int r;
		logic [2:0] c;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 45) c = CMD_QUERY;
			else if (r < 55) c = CMD_NEXT;
			else if (r < 63) c = CMD_PREV;
			else if (r < 77) c = CMD_BRIGHTEN;
			else if (r < 91) c = CMD_DARKEN;
			else if (r < 94) c = CMD_RESET;
			else if (r < 97) c = CMD_SPARE_A;
			else c = CMD_SPARE_B;
			send_command(c, 8'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_QUERY;
		hue = 8'd0;
		wr_en = 1'b0;
		wr_index = REG_BASE;
		wr_data = 8'd0;
		idle_pct = 14;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of table, pointer and registers, then spare commands, edits, pointer wrap and table reset
		send_command(CMD_QUERY, 8'h00);
		send_command(CMD_QUERY, 8'hFF);
		send_command(CMD_SPARE_A, 8'hAA);
		send_command(CMD_SPARE_B, 8'h55);
		send_command(CMD_BRIGHTEN, 8'($urandom));
		send_command(CMD_DARKEN, 8'($urandom));
		send_command(CMD_DARKEN, 8'($urandom));
		send_command(CMD_PREV, 8'($urandom));
		send_command(CMD_BRIGHTEN, 8'($urandom));
		send_command(CMD_QUERY, 8'hF8);
		send_command(CMD_NEXT, 8'($urandom));
		send_command(CMD_RESET, 8'($urandom));
		wait_for_results();

		// saturation at both ends, clamp high
		configure(8'd255, 8'd255);
		send_command(CMD_BRIGHTEN, 8'($urandom));
		send_command(CMD_QUERY, 8'h08);
		send_command(CMD_DARKEN, 8'($urandom));
		send_command(CMD_DARKEN, 8'($urandom));
		send_command(CMD_NEXT, 8'($urandom));
		send_command(CMD_QUERY, 8'h0F);
		wait_for_results();

		// zero step leaves entries alone, clamp low
		configure(8'd0, 8'd0);
		send_command(CMD_BRIGHTEN, 8'($urandom));
		send_command(CMD_DARKEN, 8'($urandom));
		send_command(CMD_QUERY, 8'h10);
		send_command(CMD_QUERY, 8'h00);
		send_command(CMD_PREV, 8'($urandom));
		wait_for_results();

		for (int p = 0; p < 6; p++) begin
			case (p)
				0: configure(8'd0, 8'd1);
				1: configure(8'd255, 8'd255);
				2: configure(8'd128, 8'($urandom_range(1, 40)));
				default: configure(8'($urandom), 8'($urandom));
			endcase
			idle_pct = (p == 2) ? 0 : 14;
			run_random(200);
			wait_for_results();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_count() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire
